// ===== sv/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared types for the trial division prime test block
// ----------------------------------------------------------------------------
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_FIN
  } state_t;

  localparam int unsigned OUT_DATA_W = 8;

endpackage

// ===== sv/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality test of one unsigned number by trial division, bit-serial divider
// ----------------------------------------------------------------------------
// usage:
//   in_*  channel: one request per number, in_tdata[WIDTH-1:0] holds the value;
//   upper bits of in_tdata are ignored. in_tready is high only while idle.
//   out_* channel: one result per request, out_tdata[0] = is_prime.
// operation:
//   0, 1 and even numbers are settled in idle and go straight to the finish
//   state. odd numbers try divisors 3, 5, 7, ... while d <= number / d; each
//   divisor runs through the restoring divider, one quotient bit per cycle,
//   then a check state tests the bound and the remainder.
//   throughput is one number at a time; the next request is taken as soon as
//   the result has moved into the output register.
// reset: rst_n low returns the engine to idle and drops out_tvalid.
// stall: a held result stays in the output register; a finished second
//   result waits in the engine until the output register frees up.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((WIDTH + 7) / 8) * 8-1:0] in_tdata,  // [WIDTH-1:0] number
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tdpt_pkg::OUT_DATA_W-1:0] out_tdata   // [0] is_prime
);

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  tdpt_pkg::state_t state_r, state_nxt;

  logic [WIDTH-1:0] num_r,  num_nxt;
  logic [WIDTH-1:0] div_r,  div_nxt;
  logic [WIDTH-1:0] rem_r,  rem_nxt;
  logic [WIDTH-1:0] quo_r,  quo_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             res_r,  res_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_prime_r,  out_prime_nxt;

  logic [WIDTH-1:0] in_num;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign in_num = in_tdata[WIDTH-1:0];
  assign trial  = {rem_r, quo_r[WIDTH-1]};
  assign diff   = trial - {1'b0, div_r};
  assign fits   = ~diff[WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tdpt_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    out_prime_nxt  = out_prime_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    in_tready      = 1'b0;

    case (state_r)
      tdpt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          num_nxt = in_num;
          div_nxt = WIDTH'(3);
          rem_nxt = '0;
          quo_nxt = in_num;
          cnt_nxt = CNT_LAST;
          if (in_num[WIDTH-1:1] == '0) begin
            // zero and one
            res_nxt   = 1'b0;
            state_nxt = tdpt_pkg::ST_FIN;
          end else if (in_num == WIDTH'(2)) begin
            res_nxt   = 1'b1;
            state_nxt = tdpt_pkg::ST_FIN;
          end else if (!in_num[0]) begin
            res_nxt   = 1'b0;
            state_nxt = tdpt_pkg::ST_FIN;
          end else begin
            state_nxt = tdpt_pkg::ST_DIV;
          end
        end
      end

      tdpt_pkg::ST_DIV: begin
        // one quotient bit per cycle
        rem_nxt = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = tdpt_pkg::ST_CHECK;
        end
      end

      tdpt_pkg::ST_CHECK: begin
        if (div_r > quo_r) begin
          // divisor past the square root
          res_nxt   = 1'b1;
          state_nxt = tdpt_pkg::ST_FIN;
        end else if (rem_r == '0) begin
          res_nxt   = 1'b0;
          state_nxt = tdpt_pkg::ST_FIN;
        end else begin
          div_nxt   = div_r + WIDTH'(2);
          rem_nxt   = '0;
          quo_nxt   = num_r;
          cnt_nxt   = CNT_LAST;
          state_nxt = tdpt_pkg::ST_DIV;
        end
      end

      tdpt_pkg::ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_prime_nxt  = res_r;
          state_nxt      = tdpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(tdpt_pkg::OUT_DATA_W - 1)'(0), out_prime_r};

endmodule

// ===== sv/tdpt_check.sv =====
// ----------------------------------------------------------------------------
// tdpt_check
// port-level checks for trial_division_prime_test, bound to the top level
// ----------------------------------------------------------------------------
module tdpt_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tdpt_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result without request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests in flight");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("ready right after a request");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tdpt_pkg::OUT_DATA_W-1:1] == '0)
    else $error("padding bits set");

endmodule

bind trial_division_prime_test tdpt_check u_tdpt_check (.*);

// ===== test/trial_division_prime_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// self-checking bench for the trial division prime test block: numbers are
// sent as requests on the in_* stream, each result on the out_* stream is
// checked against a behavioral primality predictor, with random stalls on
// both sides
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

  localparam int unsigned WIDTH          = 32;
  localparam int unsigned IN_DATA_W      = ((WIDTH + 7) / 8) * 8;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES   = 64;

  typedef struct {
    logic [WIDTH-1:0] number;
    bit               is_prime;
  } prime_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [IN_DATA_W-1:0]            in_tdata = '0;  // [31:0] number
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tdpt_pkg::OUT_DATA_W-1:0] out_tdata;       // [0] is_prime

  prime_result_t pending_results[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;

  trial_division_prime_test #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic bit trial_division_prime(input logic [WIDTH-1:0] number);
    longint unsigned value;
    longint unsigned divisor;
    value = number;
    if (value < 2) return 1'b0;
    if (value == 2) return 1'b1;
    if (value % 2 == 0) return 1'b0;
    for (divisor = 3; divisor <= value / divisor; divisor += 2) begin
      if (value % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    prime_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual is_prime %0b",
                 $time, out_tdata[0]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.is_prime) begin
          $display("%0t: is_prime mismatch for %0d: expected %0b, actual %0b",
                   $time, want.number, want.is_prime, out_tdata[0]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any request or result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("trial_division_prime_test verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_number(input logic [WIDTH-1:0] number);
    prime_result_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (!in_tready);
    entry.number   = number;
    entry.is_prime = trial_division_prime(number);
    pending_results.insert(pending_results.size(), entry);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_tiny_values();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'd3);
    send_number(32'd4);
    send_number(32'd5);
  endtask

  task automatic test_width_extremes();
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFFE);
    send_number(32'h8000_0001);
  endtask

  // odd squares and near squares where the divisor bound is exact
  task automatic test_square_bound();
    send_number(32'd9);
    send_number(32'd15);
    send_number(32'd25);
    send_number(32'd49);
    send_number(32'd121);
    send_number(32'd1018081);
    send_number(32'd1022117);
  endtask

  task automatic test_known_primes();
    send_number(32'd1009);
    send_number(32'd7919);
    send_number(32'd65521);
    send_number(32'd1000003);
  endtask

  // sender holds off until the block has returned every result
  task automatic test_pause_until_drained();
    send_number(32'd97);
    send_number(32'd99);
    in_tvalid <= 1'b0;
    wait_results_drained();
    send_number(32'd101);
  endtask

  function automatic logic [WIDTH-1:0] random_number();
    logic [WIDTH-1:0] factor;
    logic [WIDTH-1:0] multiple;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(16383);
      4, 5:       return $urandom & 32'hFFFF_FFFE;
      6, 7: begin
        // full width value with a small odd factor keeps the search short
        case ($urandom_range(4))
          0:       factor = 32'd3;
          1:       factor = 32'd5;
          2:       factor = 32'd7;
          3:       factor = 32'd11;
          default: factor = 32'd13;
        endcase
        multiple = $urandom_range(32'hFFFF_FFFF / factor);
        return factor * multiple;
      end
      default: return $urandom_range(32'h000F_FFFF);
    endcase
  endfunction

  task automatic test_random_numbers(input int unsigned count);
    repeat (count) send_number(random_number());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 50;
    test_tiny_values();
    test_width_extremes();
    test_square_bound();
    test_known_primes();
    test_pause_until_drained();
    test_random_numbers(26);

    send_idle_pct = 50;
    recv_idle_pct = 15;
    test_random_numbers(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_numbers(25);

    in_tvalid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("trial_division_prime_test verification clean");
    end else begin
      $display("trial_division_prime_test verification failed");
    end
    $finish;
  end

endmodule
